FILE: rtl/tpfc_pkg.sv
// shared types and format codes for the texture pixel format converter
`timescale 1ns / 1ps
package tpfc_pkg;

  localparam int unsigned CompWidth  = 8;
  localparam int unsigned FmtWidth   = 4;
  localparam int unsigned WordWidth  = 32;
  localparam int unsigned CountWidth = 3;
  localparam int unsigned CfgAddrWidth = 3;
  localparam int unsigned CfgDataWidth = 32;

  // luminance sum is at most 765, so (sum * 683) >> 11 is an exact floor of sum / 3
  localparam int unsigned LumSumWidth  = 10;
  localparam int unsigned LumRecip     = 683;
  localparam int unsigned LumShift     = 11;
  localparam int unsigned LumProdWidth = 20;
  localparam int unsigned IntSumWidth  = 10;

  typedef enum logic [FmtWidth-1:0] {
    FMT_A8     = 4'd0,
    FMT_L8     = 4'd1,
    FMT_LA8    = 4'd2,
    FMT_I8     = 4'd3,
    FMT_RGB332 = 4'd4,
    FMT_RGB565 = 4'd5,
    FMT_RGB8   = 4'd6,
    FMT_RGB5A1 = 4'd7,
    FMT_RGBA4  = 4'd8,
    FMT_RGBA8  = 4'd9
  } fmt_t;

  localparam logic [FmtWidth-1:0] FmtReset = FMT_RGBA8;

  // register indexes
  localparam logic [0:0] REG_TARGET_FORMAT = 1'b0;

  typedef struct packed {
    logic [CompWidth-1:0] alpha;
    logic [CompWidth-1:0] blue;
    logic [CompWidth-1:0] green;
    logic [CompWidth-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [CountWidth-1:0] byte_count;
    logic [WordWidth-1:0]  packed_bytes;
  } result_t;

endpackage

FILE: rtl/tpfc_convert.sv
// per-pixel format conversion logic
`timescale 1ns / 1ps
module tpfc_convert (
  input  tpfc_pkg::pixel_t                    pix,
  input  logic [tpfc_pkg::FmtWidth-1:0]       fmt,
  output tpfc_pkg::result_t                   res
);

  logic [tpfc_pkg::LumSumWidth-1:0]  lum_sum;
  logic [tpfc_pkg::LumProdWidth-1:0] lum_prod;
  logic [tpfc_pkg::CompWidth-1:0]    lum;
  logic [tpfc_pkg::IntSumWidth-1:0]  int_sum;
  logic [tpfc_pkg::CompWidth-1:0]    inten;
  logic [7:0] r, g, b, a;

  assign r = pix.red;
  assign g = pix.green;
  assign b = pix.blue;
  assign a = pix.alpha;

  assign lum_sum  = {2'b00, r} + {2'b00, g} + {2'b00, b};
  assign lum_prod = {{(tpfc_pkg::LumProdWidth-tpfc_pkg::LumSumWidth){1'b0}}, lum_sum}
                    * tpfc_pkg::LumProdWidth'(tpfc_pkg::LumRecip);
  assign lum      = lum_prod[tpfc_pkg::LumShift +: tpfc_pkg::CompWidth];

  assign int_sum = {2'b00, r} + {2'b00, g} + {2'b00, b} + {2'b00, a};
  assign inten   = int_sum[9:2];

  always_comb begin
    res = '0;
    case (fmt)
      tpfc_pkg::FMT_A8: begin
        res.packed_bytes = {24'd0, a};
        res.byte_count   = 3'd1;
      end
      tpfc_pkg::FMT_L8: begin
        res.packed_bytes = {24'd0, lum};
        res.byte_count   = 3'd1;
      end
      tpfc_pkg::FMT_LA8: begin
        res.packed_bytes = {16'd0, a, lum};
        res.byte_count   = 3'd2;
      end
      tpfc_pkg::FMT_I8: begin
        res.packed_bytes = {24'd0, inten};
        res.byte_count   = 3'd1;
      end
      tpfc_pkg::FMT_RGB332: begin
        res.packed_bytes = {24'd0, r[7:5], g[7:5], b[7:6]};
        res.byte_count   = 3'd1;
      end
      tpfc_pkg::FMT_RGB565: begin
        res.packed_bytes = {16'd0, r[7:3], g[7:2], b[7:3]};
        res.byte_count   = 3'd2;
      end
      tpfc_pkg::FMT_RGB8: begin
        res.packed_bytes = {8'd0, b, g, r};
        res.byte_count   = 3'd3;
      end
      tpfc_pkg::FMT_RGB5A1: begin
        res.packed_bytes = {16'd0, r[7:3], g[7:3], b[7:3], a[7]};
        res.byte_count   = 3'd2;
      end
      tpfc_pkg::FMT_RGBA4: begin
        res.packed_bytes = {16'd0, r[7:4], g[7:4], b[7:4], a[7:4]};
        res.byte_count   = 3'd2;
      end
      tpfc_pkg::FMT_RGBA8: begin
        res.packed_bytes = {a, b, g, r};
        res.byte_count   = 3'd4;
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

FILE: rtl/texture_pixel_format_converter_top.sv
// top level of the texture pixel format converter: pixel stream in, packed texels out
//
// channel  dir  payload                                        handshake
// in_      in   tdata[31:0] red, green, blue, alpha            tvalid/tready
// out_     out  tdata[39:0] packed_bytes, byte_count, pad      tvalid/tready
// cfg_     in   target_format at byte address 0                apb, pready high
//
// two register stages (input beat, result beat); one pixel per cycle while out_tready stays high
// the input register refills in the same cycle the result register drains
// rst_n synchronous, clears both valid flags and sets the format to rgba8
// a stall on out_tready holds both stages and drops in_tready once they are full
`timescale 1ns / 1ps
module texture_pixel_format_converter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // red, green, blue, alpha
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // packed_bytes[31:0], byte_count[34:32], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [tpfc_pkg::CfgAddrWidth-1:0] cfg_paddr,
  input  logic [tpfc_pkg::CfgDataWidth-1:0] cfg_pwdata,
  output logic [tpfc_pkg::CfgDataWidth-1:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [tpfc_pkg::FmtWidth-1:0] fmt_r;
  logic                          in_vld_r;
  tpfc_pkg::pixel_t              pix_r;
  logic                          out_vld_r;
  tpfc_pkg::result_t             res_r;
  tpfc_pkg::result_t             res_nxt;
  logic                          out_free;
  logic                          in_free;
  logic                          reg_hit;

  // register file
  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[2] == tpfc_pkg::REG_TARGET_FORMAT);
  assign cfg_prdata = reg_hit ? {{(tpfc_pkg::CfgDataWidth-tpfc_pkg::FmtWidth){1'b0}}, fmt_r}
                              : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= tpfc_pkg::FmtReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      fmt_r <= cfg_pwdata[tpfc_pkg::FmtWidth-1:0];
    end
  end

  // pipeline control
  assign out_free  = !out_vld_r || out_tready;
  assign in_free   = !in_vld_r || out_free;
  assign in_tready = in_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_free) begin
        in_vld_r <= in_tvalid;
      end
      if (out_free) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_free && in_tvalid) begin
      pix_r <= tpfc_pkg::pixel_t'(in_tdata);
    end
    if (out_free && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  tpfc_convert u_convert (
    .pix (pix_r),
    .fmt (fmt_r),
    .res (res_nxt)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, res_r};

endmodule

FILE: tb/texture_pixel_format_converter_top_test.sv
// self-checking testbench for the texture pixel format converter top level
`timescale 1ns / 1ps
module texture_pixel_format_converter_top_test;

  localparam logic [tpfc_pkg::CfgAddrWidth-1:0] FmtAddr =
    tpfc_pkg::CfgAddrWidth'(tpfc_pkg::REG_TARGET_FORMAT * 4);
  localparam logic [tpfc_pkg::CfgAddrWidth-1:0] SpareAddr = tpfc_pkg::CfgAddrWidth'(4);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;  // red, green, blue, alpha
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // packed_bytes, byte_count, zero pad
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [tpfc_pkg::CfgAddrWidth-1:0] cfg_paddr = '0;
  logic [tpfc_pkg::CfgDataWidth-1:0] cfg_pwdata = '0;
  logic [tpfc_pkg::CfgDataWidth-1:0] cfg_prdata;
  logic        cfg_pready;

  logic [tpfc_pkg::FmtWidth-1:0] cur_format = tpfc_pkg::FmtReset;
  tpfc_pkg::result_t texel_q[$];
  int unsigned mismatch_count = 0;
  bit idle_on = 1'b1;

  texture_pixel_format_converter_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic tpfc_pkg::result_t convert_pixel(logic [tpfc_pkg::FmtWidth-1:0] fmt,
                                                      tpfc_pkg::pixel_t px);
    int unsigned lum;
    int unsigned inten;
    tpfc_pkg::result_t res;
    lum = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
    inten = (int'(px.red) + int'(px.green) + int'(px.blue) + int'(px.alpha)) / 4;
    res = '0;
    case (fmt)
      tpfc_pkg::FMT_A8: begin
        res.packed_bytes = {24'd0, px.alpha};
        res.byte_count = 3'd1;
      end
      tpfc_pkg::FMT_L8: begin
        res.packed_bytes = {24'd0, lum[7:0]};
        res.byte_count = 3'd1;
      end
      tpfc_pkg::FMT_LA8: begin
        res.packed_bytes = {16'd0, px.alpha, lum[7:0]};
        res.byte_count = 3'd2;
      end
      tpfc_pkg::FMT_I8: begin
        res.packed_bytes = {24'd0, inten[7:0]};
        res.byte_count = 3'd1;
      end
      tpfc_pkg::FMT_RGB332: begin
        res.packed_bytes = {24'd0, px.red[7:5], px.green[7:5], px.blue[7:6]};
        res.byte_count = 3'd1;
      end
      tpfc_pkg::FMT_RGB565: begin
        res.packed_bytes = {16'd0, px.red[7:3], px.green[7:2], px.blue[7:3]};
        res.byte_count = 3'd2;
      end
      tpfc_pkg::FMT_RGB8: begin
        res.packed_bytes = {8'd0, px.blue, px.green, px.red};
        res.byte_count = 3'd3;
      end
      tpfc_pkg::FMT_RGB5A1: begin
        res.packed_bytes = {16'd0, px.red[7:3], px.green[7:3], px.blue[7:3], px.alpha[7]};
        res.byte_count = 3'd2;
      end
      tpfc_pkg::FMT_RGBA4: begin
        res.packed_bytes = {16'd0, px.red[7:4], px.green[7:4], px.blue[7:4], px.alpha[7:4]};
        res.byte_count = 3'd2;
      end
      tpfc_pkg::FMT_RGBA8: begin
        res.packed_bytes = {px.alpha, px.blue, px.green, px.red};
        res.byte_count = 3'd4;
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic tpfc_pkg::pixel_t mk_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               logic [7:0] a);
    tpfc_pkg::pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    return px;
  endfunction

  // mostly uniform, sometimes pinned to an extreme
  function automatic logic [7:0] rand_comp();
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic tpfc_pkg::pixel_t rand_pixel();
    return mk_pixel(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endfunction

  // result side: random stalls
  always @(posedge clk) begin
    if (idle_on) begin
      out_tready <= ($urandom_range(99) >= 33);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tpfc_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (texel_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual tdata %h", $time,
                 out_tdata);
        mismatch_count++;
      end else begin
        want = texel_q.pop_front();
        if (out_tdata[31:0] !== want.packed_bytes) begin
          $display("%0t: packed_bytes expected %h actual %h", $time,
                   want.packed_bytes, out_tdata[31:0]);
          mismatch_count++;
        end
        if (out_tdata[34:32] !== want.byte_count) begin
          $display("%0t: byte_count expected %0d actual %0d", $time,
                   want.byte_count, out_tdata[34:32]);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_pixel(input tpfc_pkg::pixel_t px);
    while (idle_on && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    texel_q = {texel_q, convert_pixel(cur_format, px)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (texel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [tpfc_pkg::CfgAddrWidth-1:0] addr,
                           input logic [tpfc_pkg::CfgDataWidth-1:0] data);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == FmtAddr) cur_format = data[tpfc_pkg::FmtWidth-1:0];
  endtask

  task automatic test_reset_format();
    send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(mk_pixel(8'h12, 8'h34, 8'h56, 8'h78));
  endtask

  // every 4-bit format code once, defined or not, with pixels that hit truncation and alpha msb edges
  task automatic test_every_format();
    tpfc_pkg::pixel_t edge_px[4];
    edge_px[0] = mk_pixel(8'h01, 8'h01, 8'h00, 8'h7F);
    edge_px[1] = mk_pixel(8'hFF, 8'hFF, 8'hFE, 8'h80);
    edge_px[2] = mk_pixel(8'h07, 8'h03, 8'hF8, 8'h0F);
    edge_px[3] = mk_pixel(8'hA5, 8'h5A, 8'hC3, 8'hFF);
    for (int code = 0; code < 16; code++) begin
      cfg_write(FmtAddr, tpfc_pkg::CfgDataWidth'(code));
      send_pixel(edge_px[code % 4]);
    end
  endtask

  task automatic test_register_edges();
    // out of range index leaves the format alone
    cfg_write(FmtAddr, tpfc_pkg::CfgDataWidth'(tpfc_pkg::FMT_LA8));
    cfg_write(SpareAddr, tpfc_pkg::CfgDataWidth'(tpfc_pkg::FMT_RGB332));
    send_pixel(mk_pixel(8'h10, 8'h20, 8'h30, 8'h40));
    // upper data bits are dropped
    cfg_write(FmtAddr, {28'hABCDEF1, tpfc_pkg::FMT_RGB565});
    send_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h00));
    send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 8'hFF));
  endtask

  task automatic test_random_formats();
    logic [tpfc_pkg::FmtWidth-1:0] fmt;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: fmt = tpfc_pkg::FMT_A8;
        1: fmt = tpfc_pkg::FMT_RGBA8;
        2: fmt = 4'hF;
        default: fmt = tpfc_pkg::FmtWidth'($urandom_range(15));
      endcase
      cfg_write(FmtAddr, tpfc_pkg::CfgDataWidth'(fmt));
      repeat (62) send_pixel(rand_pixel());
    end
  endtask

  task automatic test_back_to_back();
    cfg_write(FmtAddr, tpfc_pkg::CfgDataWidth'($urandom_range(tpfc_pkg::FMT_RGBA8)));
    idle_on = 1'b0;
    repeat (150) send_pixel(rand_pixel());
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_format();
    test_every_format();
    test_register_edges();
    test_random_formats();
    test_back_to_back();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
